// ===== rtl/line_follow_pid_steering_defines.svh =====
// Assertion macros shared by the line-follow steering RTL.
// Needs no other file; the checks compile away when SYNTHESIS is defined.
`ifndef LINE_FOLLOW_PID_STEERING_DEFINES_SVH
`define LINE_FOLLOW_PID_STEERING_DEFINES_SVH
`ifndef SYNTHESIS
`define LFPS_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("lfps assertion failed");
`define LFPS_ASSERT_ALWAYS(name, clk, prop) \
    name: assert property (@(posedge clk) (prop)) \
        else $error("lfps assertion failed");
`else
`define LFPS_ASSERT(name, clk, rst_n, prop)
`define LFPS_ASSERT_ALWAYS(name, clk, prop)
`endif
`endif

// ===== rtl/lfps_pkg.sv =====
`timescale 1ns / 1ps
// Types, constants and the microcode program of the line-follow steering block.
// Used by the sequencer, the datapath and the top level; depends on nothing.
package lfps_pkg;

    localparam int SAMPLE_BITS = 12;

    localparam int CENTER_W = 12;
    localparam int RECIP_W  = 16;
    localparam int GAIN_W   = 16;
    localparam int BAND_W   = 15;
    localparam int LIMIT_W  = 16;
    localparam int SPEED_W  = 16;
    localparam int CORR_W   = 16;
    localparam int ERR_W    = 16;
    localparam int SUM_W    = 29;

    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 16;

    localparam int DIFF_W   = ((SAMPLE_BITS > CENTER_W) ? SAMPLE_BITS : CENTER_W) + 1;
    localparam int MUL_W    = 32;
    localparam int PROD_W   = 2 * MUL_W;
    localparam int ACC_W    = 32;
    localparam int DDIFF_W  = ERR_W + 1;
    localparam int GD100_W  = GAIN_W + 7;
    localparam int IDIV_W   = 31;
    localparam int Q_W      = 27;
    localparam int DRV_W    = SPEED_W + 2;

    localparam int SHIFT_ERR       = 10;
    localparam int SHIFT_PD        = 11;
    localparam int DIV_SHIFT       = 13;
    localparam int DIV_MAGIC_SHIFT = 35;
    localparam logic [IDIV_W-1:0] DIV_MAGIC = 31'd1374389535;

    localparam logic signed [ERR_W-1:0]   ERR_ONE      = 16'sd16384;
    localparam logic signed [SUM_W-1:0]   SUM_LIMIT    = 29'sd163840000;
    localparam logic signed [ACC_W-1:0]   ACC_CORR_MAX = 32'sd32767;
    localparam logic signed [ACC_W-1:0]   ACC_CORR_MIN = -32'sd32768;
    localparam logic signed [DRV_W-1:0]   DRV_MAX      = 18'sd32768;
    localparam logic [SPEED_W-1:0]        DRIVE_MAX    = 16'd32768;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_CENTER = 4'd0,
        REG_RECIP  = 4'd1,
        REG_GAIN_P = 4'd2,
        REG_GAIN_I = 4'd3,
        REG_GAIN_D = 4'd4,
        REG_BAND   = 4'd5,
        REG_LIMIT  = 4'd6,
        REG_BASE   = 4'd7
    } reg_idx_t;

    typedef struct packed {
        logic [CENTER_W-1:0] center_threshold;
        logic [RECIP_W-1:0]  threshold_reciprocal;
        logic [GAIN_W-1:0]   gain_p;
        logic [GAIN_W-1:0]   gain_i;
        logic [GAIN_W-1:0]   gain_d;
        logic [BAND_W-1:0]   dead_band;
        logic [LIMIT_W-1:0]  correction_limit;
        logic [SPEED_W-1:0]  cruise_speed;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        center_threshold:     12'd1350,
        threshold_reciprocal: 16'd12428,
        gain_p:               16'd819,
        gain_i:               16'd0,
        gain_d:               16'd82,
        dead_band:            15'd1311,
        correction_limit:     16'd6554,
        cruise_speed:         16'd9830
    };

    localparam int STEP_W = 4;

    typedef enum logic [1:0] {
        JMP_NEXT,
        JMP_WAIT_IN,
        JMP_WAIT_OUT
    } jmp_t;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_ERR,
        MUL_P,
        MUL_I,
        MUL_D,
        MUL_DIV
    } mul_sel_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD_SHR,
        ACC_ADD_Q
    } acc_op_t;

    typedef struct packed {
        jmp_t              jmp;
        logic [STEP_W-1:0] target;
        mul_sel_t          mul;
        acc_op_t           acc;
        logic              in_ready;
        logic              ld_err;
        logic              ld_sum;
        logic              ld_idiv;
        logic              commit;
        logic              ld_corr;
        logic              ld_out;
    } ucode_t;

    typedef struct packed {
        logic in_valid;
        logic out_free;
    } cond_t;

    localparam logic [STEP_W-1:0] STEP_IDLE   = 4'd0;
    localparam logic [STEP_W-1:0] STEP_MUL_E  = 4'd1;
    localparam logic [STEP_W-1:0] STEP_ERR    = 4'd2;
    localparam logic [STEP_W-1:0] STEP_MUL_P  = 4'd3;
    localparam logic [STEP_W-1:0] STEP_P      = 4'd4;
    localparam logic [STEP_W-1:0] STEP_IDIV   = 4'd5;
    localparam logic [STEP_W-1:0] STEP_D      = 4'd6;
    localparam logic [STEP_W-1:0] STEP_I      = 4'd7;
    localparam logic [STEP_W-1:0] STEP_CORR   = 4'd8;
    localparam logic [STEP_W-1:0] STEP_DRIVE  = 4'd9;

    localparam ucode_t UC_NOP = '{
        jmp: JMP_NEXT, target: STEP_IDLE, mul: MUL_NONE, acc: ACC_HOLD,
        in_ready: 1'b0, ld_err: 1'b0, ld_sum: 1'b0, ld_idiv: 1'b0,
        commit: 1'b0, ld_corr: 1'b0, ld_out: 1'b0
    };

    function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
        ucode_t uc;
        uc = UC_NOP;
        case (step)
            STEP_IDLE: begin
                uc.jmp = JMP_WAIT_IN;
                uc.in_ready = 1'b1;
            end
            STEP_MUL_E: begin
                uc.mul = MUL_ERR;
            end
            STEP_ERR: begin
                uc.ld_err = 1'b1;
            end
            STEP_MUL_P: begin
                uc.mul = MUL_P;
                uc.ld_sum = 1'b1;
            end
            STEP_P: begin
                uc.acc = ACC_LOAD;
                uc.mul = MUL_I;
            end
            STEP_IDIV: begin
                uc.ld_idiv = 1'b1;
                uc.mul = MUL_D;
            end
            STEP_D: begin
                uc.acc = ACC_ADD_SHR;
                uc.mul = MUL_DIV;
            end
            STEP_I: begin
                uc.acc = ACC_ADD_Q;
                uc.commit = 1'b1;
            end
            STEP_CORR: begin
                uc.ld_corr = 1'b1;
            end
            STEP_DRIVE: begin
                uc.ld_out = 1'b1;
                uc.jmp = JMP_WAIT_OUT;
                uc.target = STEP_IDLE;
            end
            default: begin
                uc.jmp = JMP_WAIT_OUT;
                uc.target = STEP_IDLE;
            end
        endcase
        return uc;
    endfunction

endpackage

// ===== rtl/line_follow_pid_steering.sv =====
`timescale 1ns / 1ps
// Line-follow PID steering: a sample transaction is accepted while the sequencer is idle,
// and its result is loaded into the output register in the last step of the ten-step
// microcode program around one shared 32x32 multiplier; no new sample is accepted until
// the program is back in idle, and its last step waits while the output register still
// holds a result. Reset (aresetn, synchronous, active low) restores the configuration and
// step counter, clears the previous error and the error sum, and drops any pending result.
`include "line_follow_pid_steering_defines.svh"
module line_follow_pid_steering import lfps_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [SAMPLE_BITS-1:0]    s_sensor_sample,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [SPEED_W-1:0]        m_left_drive,
    output logic [SPEED_W-1:0]        m_right_drive,
    output logic signed [CORR_W-1:0]  m_steer_correction,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data
);

    cfg_t   cfg_reg;
    cfg_t   cfg_next;
    ucode_t ctrl;
    cond_t  cond;

    logic                     in_accept;
    logic                     out_free;
    logic                     out_load;
    logic                     m_valid_reg;
    logic                     m_valid_next;
    logic [SPEED_W-1:0]       left_reg;
    logic [SPEED_W-1:0]       right_reg;
    logic signed [CORR_W-1:0] steer_reg;
    logic [SPEED_W-1:0]       dp_left;
    logic [SPEED_W-1:0]       dp_right;
    logic signed [CORR_W-1:0] dp_corr;
    logic signed [LIMIT_W:0]  lim_ext;
    logic                     drive_in_range;
    logic                     corr_in_limit;

    assign cfg_ready = 1'b1;
    assign s_ready   = ctrl.in_ready;
    assign in_accept = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign out_load  = ctrl.ld_out && out_free;
    assign cond      = '{in_valid: s_valid, out_free: out_free};

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (reg_idx_t'(cfg_index))
                REG_CENTER: cfg_next.center_threshold     = cfg_data[CENTER_W-1:0];
                REG_RECIP:  cfg_next.threshold_reciprocal = cfg_data[RECIP_W-1:0];
                REG_GAIN_P: cfg_next.gain_p               = cfg_data[GAIN_W-1:0];
                REG_GAIN_I: cfg_next.gain_i               = cfg_data[GAIN_W-1:0];
                REG_GAIN_D: cfg_next.gain_d               = cfg_data[GAIN_W-1:0];
                REG_BAND:   cfg_next.dead_band            = cfg_data[BAND_W-1:0];
                REG_LIMIT:  cfg_next.correction_limit     = cfg_data[LIMIT_W-1:0];
                REG_BASE:   cfg_next.cruise_speed         = cfg_data[SPEED_W-1:0];
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg     <= CFG_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            cfg_reg     <= cfg_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            left_reg  <= dp_left;
            right_reg <= dp_right;
            steer_reg <= dp_corr;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_left_drive       = left_reg;
    assign m_right_drive      = right_reg;
    assign m_steer_correction = steer_reg;
    assign lim_ext            = {1'b0, cfg_reg.correction_limit};
    assign drive_in_range     = m_left_drive <= DRIVE_MAX && m_right_drive <= DRIVE_MAX;
    assign corr_in_limit      = m_steer_correction <= lim_ext
                                && m_steer_correction >= -lim_ext;

    lfps_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cond    (cond),
        .ctrl    (ctrl)
    );

    lfps_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctrl        (ctrl),
        .cfg         (cfg_reg),
        .in_accept   (in_accept),
        .sample      (s_sensor_sample),
        .left_drive  (dp_left),
        .right_drive (dp_right),
        .corr        (dp_corr)
    );

    `LFPS_ASSERT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready |=> !s_ready)
    `LFPS_ASSERT(a_load_from_seq, aclk, aresetn, $rose(m_valid) |-> $past(ctrl.ld_out))
    `LFPS_ASSERT(a_drive_range, aclk, aresetn, m_valid |-> drive_in_range)
    `LFPS_ASSERT(a_corr_limit, aclk, aresetn, m_valid |-> corr_in_limit)

endmodule

// ===== rtl/lfps_seq.sv =====
`timescale 1ns / 1ps
// Microcode sequencer: step counter, program table lookup and jump logic.
// Depends on lfps_pkg for the control word, the condition group and the program.
module lfps_seq import lfps_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  cond_t  cond,
    output ucode_t ctrl
);

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;

    assign ctrl = ucode_rom(step_reg);

    always_comb begin
        case (ctrl.jmp)
            JMP_NEXT:     step_next = step_reg + STEP_W'(1);
            JMP_WAIT_IN:  step_next = cond.in_valid ? step_reg + STEP_W'(1) : step_reg;
            JMP_WAIT_OUT: step_next = cond.out_free ? ctrl.target : step_reg;
            default:      step_next = STEP_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= STEP_IDLE;
        end else begin
            step_reg <= step_next;
        end
    end

endmodule

// ===== rtl/lfps_dp.sv =====
`timescale 1ns / 1ps
// Datapath: shared multiplier, error shaping, PID accumulation and output saturation.
// Depends on lfps_pkg; every step is driven by the sequencer's control word.
module lfps_dp import lfps_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  ucode_t                    ctrl,
    input  cfg_t                      cfg,
    input  logic                      in_accept,
    input  logic [SAMPLE_BITS-1:0]    sample,
    output logic [SPEED_W-1:0]        left_drive,
    output logic [SPEED_W-1:0]        right_drive,
    output logic signed [CORR_W-1:0]  corr
);

    function automatic logic signed [PROD_W-1:0] shr_tz(
        input logic signed [PROD_W-1:0] v,
        input int unsigned              sh
    );
        logic signed [PROD_W-1:0] bias;
        bias = v[PROD_W-1] ? ((PROD_W'(1) << sh) - PROD_W'(1)) : '0;
        return (v + bias) >>> sh;
    endfunction

    logic signed [DIFF_W-1:0]  diff_reg;
    logic signed [ERR_W-1:0]   err_reg;
    logic signed [SUM_W-1:0]   sum_tmp_reg;
    logic signed [DDIFF_W-1:0] ddiff_reg;
    logic [GD100_W-1:0]        gd100_reg;
    logic                      i_neg_reg;
    logic [IDIV_W-1:0]         idiv_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [CORR_W-1:0]  corr_reg;
    logic signed [ERR_W-1:0]   last_err_reg;
    logic signed [SUM_W-1:0]   error_sum_reg;

    logic signed [MUL_W-1:0]   mul_a;
    logic signed [MUL_W-1:0]   mul_b;
    logic signed [PROD_W-1:0]  prod_shr;
    logic signed [PROD_W-1:0]  err_shr;
    logic signed [ERR_W-1:0]   err_cl;
    logic [BAND_W-1:0]         err_mag;
    logic signed [ERR_W-1:0]   err_db;
    logic [PROD_W-1:0]         prod_mag;
    logic [Q_W-1:0]            quot;
    logic signed [ACC_W-1:0]   i_term;
    logic signed [ACC_W-1:0]   lim_s;
    logic signed [ACC_W-1:0]   corr_lim;
    logic signed [ACC_W-1:0]   corr_sat;
    logic signed [SUM_W-1:0]   sum_clamped;
    logic signed [DRV_W-1:0]   left_raw;
    logic signed [DRV_W-1:0]   right_raw;

    always_comb begin
        case (ctrl.mul)
            MUL_ERR: begin
                mul_a = MUL_W'(diff_reg);
                mul_b = MUL_W'(cfg.threshold_reciprocal);
            end
            MUL_P: begin
                mul_a = MUL_W'(cfg.gain_p);
                mul_b = MUL_W'(err_reg);
            end
            MUL_I: begin
                mul_a = MUL_W'(cfg.gain_i);
                mul_b = MUL_W'(sum_tmp_reg);
            end
            MUL_D: begin
                mul_a = MUL_W'(gd100_reg);
                mul_b = MUL_W'(ddiff_reg);
            end
            MUL_DIV: begin
                mul_a = MUL_W'(idiv_reg);
                mul_b = MUL_W'(DIV_MAGIC);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        prod_shr = shr_tz(prod_reg, SHIFT_PD);
        err_shr  = shr_tz(prod_reg, SHIFT_ERR);

        if (err_shr > PROD_W'(ERR_ONE)) begin
            err_cl = ERR_ONE;
        end else if (err_shr < -PROD_W'(ERR_ONE)) begin
            err_cl = -ERR_ONE;
        end else begin
            err_cl = ERR_W'(err_shr);
        end
        err_mag = err_cl[ERR_W-1] ? BAND_W'(-err_cl) : BAND_W'(err_cl);
        err_db  = (err_mag < cfg.dead_band) ? '0 : err_cl;

        prod_mag = prod_reg[PROD_W-1] ? PROD_W'(-prod_reg) : PROD_W'(prod_reg);
        quot     = prod_reg[DIV_MAGIC_SHIFT +: Q_W];
        i_term   = i_neg_reg ? -ACC_W'(quot) : ACC_W'(quot);

        lim_s = ACC_W'(cfg.correction_limit);
        if (acc_reg > lim_s) begin
            corr_lim = lim_s;
        end else if (acc_reg < -lim_s) begin
            corr_lim = -lim_s;
        end else begin
            corr_lim = acc_reg;
        end
        if (corr_lim > ACC_CORR_MAX) begin
            corr_sat = ACC_CORR_MAX;
        end else if (corr_lim < ACC_CORR_MIN) begin
            corr_sat = ACC_CORR_MIN;
        end else begin
            corr_sat = corr_lim;
        end

        if (sum_tmp_reg > SUM_LIMIT) begin
            sum_clamped = SUM_LIMIT;
        end else if (sum_tmp_reg < -SUM_LIMIT) begin
            sum_clamped = -SUM_LIMIT;
        end else begin
            sum_clamped = sum_tmp_reg;
        end

        left_raw  = DRV_W'(cfg.cruise_speed) - DRV_W'(corr_reg);
        right_raw = DRV_W'(cfg.cruise_speed) + DRV_W'(corr_reg);
    end

    always_comb begin
        if (left_raw < 0) begin
            left_drive = '0;
        end else if (left_raw > DRV_MAX) begin
            left_drive = DRIVE_MAX;
        end else begin
            left_drive = SPEED_W'(left_raw);
        end
        if (right_raw < 0) begin
            right_drive = '0;
        end else if (right_raw > DRV_MAX) begin
            right_drive = DRIVE_MAX;
        end else begin
            right_drive = SPEED_W'(right_raw);
        end
    end

    assign corr = corr_reg;

    always_ff @(posedge aclk) begin
        prod_reg  <= mul_a * mul_b;
        gd100_reg <= (GD100_W'(cfg.gain_d) << 6) + (GD100_W'(cfg.gain_d) << 5)
                   + (GD100_W'(cfg.gain_d) << 2);
        if (in_accept) begin
            diff_reg <= DIFF_W'(sample) - DIFF_W'(cfg.center_threshold);
        end
        if (ctrl.ld_err) begin
            err_reg <= err_db;
        end
        if (ctrl.ld_sum) begin
            sum_tmp_reg <= error_sum_reg + SUM_W'(err_reg);
            ddiff_reg   <= DDIFF_W'(err_reg) - DDIFF_W'(last_err_reg);
        end
        if (ctrl.ld_idiv) begin
            i_neg_reg <= prod_reg[PROD_W-1];
            idiv_reg  <= prod_mag[DIV_SHIFT +: IDIV_W];
        end
        case (ctrl.acc)
            ACC_LOAD:    acc_reg <= ACC_W'(prod_shr);
            ACC_ADD_SHR: acc_reg <= acc_reg + ACC_W'(prod_shr);
            ACC_ADD_Q:   acc_reg <= acc_reg + i_term;
            default:     acc_reg <= acc_reg;
        endcase
        if (ctrl.ld_corr) begin
            corr_reg <= CORR_W'(corr_sat);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_err_reg  <= '0;
            error_sum_reg <= '0;
        end else if (ctrl.commit) begin
            last_err_reg  <= err_reg;
            error_sum_reg <= sum_clamped;
        end
    end

endmodule

// ===== dv/tb_line_follow_pid_steering.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for line_follow_pid_steering: a queued sample driver, a result
// monitor and a bit-exact steering predictor. Depends on lfps_pkg and the block's RTL.
module tb_line_follow_pid_steering;
    import lfps_pkg::*;

    localparam int     SETTLE_CYCLES  = 16;
    localparam int     WATCHDOG_LIMIT = 4000;
    localparam int     PRINT_CAP      = 40;
    localparam longint I_DIVISOR      = 204800;
    localparam longint D_RATE         = 100;
    localparam longint ERR_FULL       = longint'(ERR_ONE);
    localparam longint SUM_CAP        = longint'(SUM_LIMIT);
    localparam logic [CFG_INDEX_W-1:0] REG_FIRST_UNUSED = 4'd8;
    localparam logic [CFG_INDEX_W-1:0] REG_LAST_UNUSED  = 4'd15;

    typedef struct packed {
        logic [SPEED_W-1:0]       left;
        logic [SPEED_W-1:0]       right;
        logic signed [CORR_W-1:0] steer;
    } drive_t;

    typedef struct packed {
        logic [CFG_INDEX_W-1:0] index;
        logic [CFG_DATA_W-1:0]  data;
    } reg_write_t;

    logic                     aclk;
    logic                     aresetn = 1'b0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic [SAMPLE_BITS-1:0]   s_sensor_sample = '0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic [SPEED_W-1:0]       m_left_drive;
    logic [SPEED_W-1:0]       m_right_drive;
    logic signed [CORR_W-1:0] m_steer_correction;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_INDEX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]    cfg_data = '0;

    logic [SAMPLE_BITS-1:0] sample_q[$];
    drive_t                 drive_expect_q[$];
    reg_write_t             reg_write_q[$];

    cfg_t   model_cfg = CFG_RESET;
    longint prev_err = 0;
    longint acc_err = 0;

    int mismatch_count = 0;
    int burst_left = 0;
    int gap_left = 0;
    int ready_hold = 0;
    int quiet_cycles = 0;

    line_follow_pid_steering dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_sensor_sample    (s_sensor_sample),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_left_drive       (m_left_drive),
        .m_right_drive      (m_right_drive),
        .m_steer_correction (m_steer_correction),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic longint shr_tz(input longint v, input int sh);
        return (v < 0) ? -((-v) >>> sh) : (v >>> sh);
    endfunction

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic drive_t predict_drive(input logic [SAMPLE_BITS-1:0] raw);
        longint s, c, recip, gp, gi, gd, band, lim, base;
        longint err, mag, p, i, d, corr;
        drive_t r;
        s = raw;
        c = model_cfg.center_threshold;
        recip = model_cfg.threshold_reciprocal;
        gp = model_cfg.gain_p;
        gi = model_cfg.gain_i;
        gd = model_cfg.gain_d;
        band = model_cfg.dead_band;
        lim = model_cfg.correction_limit;
        base = model_cfg.cruise_speed;
        err = clamp(shr_tz((s - c) * recip, SHIFT_ERR), -ERR_FULL, ERR_FULL);
        mag = (err < 0) ? -err : err;
        if (mag < band) err = 0;
        p = shr_tz(gp * err, SHIFT_PD);
        acc_err = acc_err + err;
        i = (gi * acc_err) / I_DIVISOR;
        d = shr_tz(gd * (err - prev_err) * D_RATE, SHIFT_PD);
        prev_err = err;
        acc_err = clamp(acc_err, -SUM_CAP, SUM_CAP);
        corr = clamp(p + i + d, -lim, lim);
        corr = clamp(corr, longint'(ACC_CORR_MIN), longint'(ACC_CORR_MAX));
        r.left = SPEED_W'(clamp(base - corr, 0, longint'(DRIVE_MAX)));
        r.right = SPEED_W'(clamp(base + corr, 0, longint'(DRIVE_MAX)));
        r.steer = CORR_W'(corr);
        return r;
    endfunction

    function automatic void apply_reg(input reg_write_t w);
        case (w.index)
            REG_CENTER: model_cfg.center_threshold = w.data[CENTER_W-1:0];
            REG_RECIP:  model_cfg.threshold_reciprocal = w.data[RECIP_W-1:0];
            REG_GAIN_P: model_cfg.gain_p = w.data[GAIN_W-1:0];
            REG_GAIN_I: model_cfg.gain_i = w.data[GAIN_W-1:0];
            REG_GAIN_D: model_cfg.gain_d = w.data[GAIN_W-1:0];
            REG_BAND:   model_cfg.dead_band = w.data[BAND_W-1:0];
            REG_LIMIT:  model_cfg.correction_limit = w.data[LIMIT_W-1:0];
            REG_BASE:   model_cfg.cruise_speed = w.data[SPEED_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] reg_value(input int r, input int mode);
        int pick;
        pick = (mode == 0) ? 0 : (mode == 1) ? 2 : $urandom_range(0, 9);
        case (pick)
            0: return '0;
            1: begin
                case (r)
                    REG_CENTER: return 16'd4095;
                    REG_BAND:   return 16'd16384;
                    REG_LIMIT:  return 16'd32768;
                    REG_BASE:   return 16'd32768;
                    default:    return 16'hFFFF;
                endcase
            end
            2: return 16'hFFFF;
            3: return CFG_DATA_W'($urandom);
            default: begin
                case (r)
                    REG_CENTER: return CFG_DATA_W'($urandom_range(0, 4095));
                    REG_RECIP:  return CFG_DATA_W'($urandom_range(2000, 40000));
                    REG_BAND:   return CFG_DATA_W'($urandom_range(0, 4000));
                    REG_LIMIT:  return CFG_DATA_W'($urandom_range(0, 32768));
                    REG_BASE:   return CFG_DATA_W'($urandom_range(0, 32768));
                    default:    return CFG_DATA_W'($urandom_range(0, 8192));
                endcase
            end
        endcase
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] pick_sample();
        int v;
        case ($urandom_range(0, 9))
            6, 7: begin
                v = int'(model_cfg.center_threshold) + $urandom_range(0, 400) - 200;
                return SAMPLE_BITS'(clamp(v, 0, 4095));
            end
            8: return $urandom_range(0, 1) ? '1 : '0;
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
            $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    endtask

    task automatic set_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
        reg_write_t w;
        w.index = idx;
        w.data = v;
        reg_write_q.push_back(w);
    endtask

    task automatic commit_regs();
        reg_write_t w;
        while (reg_write_q.size() > 0) begin
            w = reg_write_q.pop_front();
            cfg_valid <= 1'b1;
            cfg_index <= w.index;
            cfg_data <= w.data;
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
            apply_reg(w);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (sample_q.size() != 0 || s_valid || drive_expect_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    always @(posedge aclk) begin : sample_driver
        if (!aresetn) begin
            s_valid <= 1'b0;
            burst_left <= $urandom_range(1, 40);
            gap_left <= 0;
        end else begin
            if (s_valid && s_ready)
                drive_expect_q.push_back(predict_drive(s_sensor_sample));
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_valid <= 1'b0;
                end else if (sample_q.size() > 0) begin
                    s_valid <= 1'b1;
                    s_sensor_sample <= sample_q.pop_front();
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : result_stall
        int run;
        if (!aresetn) begin
            m_ready <= 1'b0;
            ready_hold <= 0;
        end else if (ready_hold == 0) begin
            case ($urandom_range(0, 3))
                0: begin
                    m_ready <= 1'b0;
                    run = $urandom_range(1, 25);
                end
                1: begin
                    m_ready <= 1'b1;
                    run = $urandom_range(50, 200);
                end
                default: begin
                    m_ready <= 1'b1;
                    run = $urandom_range(1, 8);
                end
            endcase
            ready_hold <= run;
        end else begin
            ready_hold <= ready_hold - 1;
        end
    end

    always @(posedge aclk) begin : result_monitor
        drive_t want;
        if (aresetn && m_valid && m_ready) begin
            if (drive_expect_q.size() == 0) begin
                report_mismatch("result with no sample pending", 1, 0);
            end else begin
                want = drive_expect_q.pop_front();
                if (m_left_drive !== want.left)
                    report_mismatch("left_drive", m_left_drive, want.left);
                if (m_right_drive !== want.right)
                    report_mismatch("right_drive", m_right_drive, want.right);
                if (m_steer_correction !== want.steer)
                    report_mismatch("steer_correction", m_steer_correction, want.steer);
            end
        end
    end

    always @(posedge aclk) begin : watchdog
        if (!aresetn) begin
            quiet_cycles <= 0;
        end else if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_line_follow_pid_steering NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        int ph;
        int r;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        sample_q = {12'd1350, 12'd1458, 12'd1459, 12'd1242, 12'd1241,
                    12'd0, 12'd4095, 12'd4095, 12'd0, 12'd2048};
        drain();

        set_reg(REG_FIRST_UNUSED, 16'hFFFF);
        set_reg(REG_LAST_UNUSED, 16'h0000);
        set_reg(REG_RECIP, 16'd0);
        commit_regs();
        sample_q = {12'd0, 12'd4095};
        drain();

        set_reg(REG_RECIP, 16'd12428);
        set_reg(REG_BAND, 16'hFFFF);
        commit_regs();
        sample_q = {12'd4095, 12'd0};
        drain();

        set_reg(REG_BAND, 16'd0);
        set_reg(REG_GAIN_P, 16'hFFFF);
        set_reg(REG_GAIN_D, 16'hFFFF);
        set_reg(REG_LIMIT, 16'd32768);
        set_reg(REG_BASE, 16'd32768);
        set_reg(REG_CENTER, 16'hFFFF);
        commit_regs();
        sample_q = {12'd0, 12'd4095, 12'd2048};
        drain();

        set_reg(REG_CENTER, 16'd2048);
        set_reg(REG_BASE, 16'd0);
        set_reg(REG_LIMIT, 16'd0);
        commit_regs();
        sample_q = {12'd0, 12'd4095};
        drain();

        for (ph = 0; ph < 8; ph++) begin
            for (r = REG_CENTER; r <= REG_BASE; r++)
                set_reg(CFG_INDEX_W'(r), reg_value(r, ph));
            if ($urandom_range(0, 1))
                set_reg(REG_FIRST_UNUSED + CFG_INDEX_W'($urandom_range(0, 7)),
                        CFG_DATA_W'($urandom));
            commit_regs();
            repeat ($urandom_range(130, 170)) sample_q.push_back(pick_sample());
            drain();
        end

        // Build up the error sum from one side with a small integral gain so that the
        // I term alone steers, then unwind it past zero from the other side.
        set_reg(REG_CENTER, 16'd0);
        set_reg(REG_RECIP, 16'hFFFF);
        set_reg(REG_GAIN_P, 16'd0);
        set_reg(REG_GAIN_I, CFG_DATA_W'($urandom_range(1, 512)));
        set_reg(REG_GAIN_D, 16'd0);
        set_reg(REG_BAND, 16'd0);
        set_reg(REG_LIMIT, 16'd32768);
        set_reg(REG_BASE, 16'd16384);
        commit_regs();
        repeat (250) sample_q.push_back(SAMPLE_BITS'($urandom_range(256, 4095)));
        drain();
        set_reg(REG_CENTER, 16'd4095);
        commit_regs();
        repeat (300) sample_q.push_back(SAMPLE_BITS'($urandom_range(0, 3839)));
        drain();

        if (drive_expect_q.size() != 0)
            report_mismatch("results still outstanding", 0, drive_expect_q.size());
        if (mismatch_count == 0) begin
            $display("tb_line_follow_pid_steering OK");
        end else begin
            $display("tb_line_follow_pid_steering NOT OK");
        end
        $finish;
    end

endmodule
